>>> hdl/rpse_pkg.sv
// Package for the row position symbol encoder.
// Field widths, symbol codes, prefixes and the result struct.
// No dependencies.
`default_nettype none

package rpse_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int SYM_W     = 2;
    localparam int RW_W      = 13;
    localparam int CODE_W    = 15;
    localparam int LEN_W     = 4;
    localparam int BITS_W    = 4;

    localparam logic [RW_W-1:0] ROW_WIDTH_RESET = RW_W'(4096);

    localparam logic [SYM_W-1:0] SYM_NONE   = 2'd0;
    localparam logic [SYM_W-1:0] SYM_START  = 2'd1;
    localparam logic [SYM_W-1:0] SYM_END    = 2'd2;
    localparam logic [SYM_W-1:0] SYM_SINGLE = 2'd3;

    localparam logic [2:0] PRE_START  = 3'b011;
    localparam logic [2:0] PRE_END    = 3'b101;
    localparam logic [2:0] PRE_SINGLE = 3'b100;

    localparam logic [LEN_W-1:0] PLEN_START = 4'd2;
    localparam logic [LEN_W-1:0] PLEN_OTHER = 4'd3;

    typedef struct packed {
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic              row_done;
    } rpse_result_t;

endpackage

`default_nettype wire

>>> hdl/rpse_ifs.sv
// Channel interfaces: symbol input, code output, row width write.
// Depends on rpse_pkg.
`default_nettype none

interface rpse_sym_if;
    logic                       valid;
    logic                       ready;
    logic [rpse_pkg::SYM_W-1:0] symbol;
    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface rpse_code_if;
    logic                        valid;
    logic                        ready;
    logic [rpse_pkg::CODE_W-1:0] code_bits;
    logic [rpse_pkg::LEN_W-1:0]  code_length;
    logic                        row_done;
    modport source (output valid, output code_bits, output code_length, output row_done,
                    input ready);
    modport sink   (input valid, input code_bits, input code_length, input row_done,
                    output ready);
endinterface

interface rpse_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [rpse_pkg::RW_W-1:0] row_width;
    modport source (output valid, output row_width, input ready);
    modport sink   (input valid, input row_width, output ready);
endinterface

`default_nettype wire

>>> hdl/rpse_core.sv
// Row state (column, last marker, seen flag) and the codeword builder.
// Depends on rpse_pkg.
`default_nettype none

module rpse_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [rpse_pkg::SYM_W-1:0] symbol,
    input  wire logic                       cfg_we,
    input  wire logic [rpse_pkg::RW_W-1:0]  cfg_width,
    output logic                            res_valid,
    output rpse_pkg::rpse_result_t          res
);
    import rpse_pkg::*;

    logic [RW_W-1:0]  row_width_reg, row_width_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] lmc_reg, lmc_next;
    logic             seen_reg, seen_next;

    logic [RW_W-1:0]   eff_w;
    logic              last;
    logic [RW_W-1:0]   span;
    logic [RW_W-1:0]   span_m1;
    logic [BITS_W-1:0] nbits;
    logic [COL_W-1:0]  gap;
    logic [RW_W-1:0]   mask;
    logic [2:0]        pre;
    logic [LEN_W-1:0]  plen;

    always_comb
    begin
        if (row_width_reg == '0)
        begin
            eff_w = RW_W'(1);
        end
        else if (row_width_reg > RW_W'(MAX_WIDTH))
        begin
            eff_w = RW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = row_width_reg;
        end
    end

    assign last = ({1'b0, col_reg} + RW_W'(1)) >= eff_w;

    // span = W - last marker - seen, floor of 1
    always_comb
    begin
        span = eff_w - {1'b0, lmc_reg} - RW_W'(seen_reg);
        if (span == '0)
        begin
            span = RW_W'(1);
        end
        span_m1 = span - RW_W'(1);
    end

    // ceil-log2(span) = bit length of span-1, at least 1
    always_comb
    begin
        nbits = BITS_W'(1);
        for (int i = 0; i < RW_W; i++)
        begin
            if (span_m1[i])
            begin
                nbits = BITS_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        gap  = seen_reg ? (col_reg - lmc_reg - COL_W'(1)) : col_reg;
        mask = (RW_W'(1) << nbits) - RW_W'(1);
        case (symbol)
            SYM_START:
            begin
                pre  = PRE_START;
                plen = PLEN_START;
            end
            SYM_END:
            begin
                pre  = PRE_END;
                plen = PLEN_OTHER;
            end
            default:
            begin
                pre  = PRE_SINGLE;
                plen = PLEN_OTHER;
            end
        endcase
    end

    always_comb
    begin
        res_valid = accept && ((symbol != SYM_NONE) || last);
        res.row_done = last;
        if (symbol == SYM_NONE)
        begin
            res.code_bits   = '0;
            res.code_length = LEN_W'(1);
        end
        else
        begin
            res.code_bits   = (CODE_W'(pre) << nbits)
                            | CODE_W'(gap & mask[COL_W-1:0]);
            res.code_length = plen + LEN_W'(nbits);
        end
    end

    always_comb
    begin
        row_width_next = row_width_reg;
        col_next       = col_reg;
        lmc_next       = lmc_reg;
        seen_next      = seen_reg;
        if (cfg_we)
        begin
            row_width_next = cfg_width;
            col_next       = '0;
            lmc_next       = '0;
            seen_next      = 1'b0;
        end
        else if (accept)
        begin
            if (symbol != SYM_NONE)
            begin
                lmc_next  = col_reg;
                seen_next = 1'b1;
            end
            if (last)
            begin
                col_next  = '0;
                lmc_next  = '0;
                seen_next = 1'b0;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
            col_reg       <= '0;
            lmc_reg       <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            row_width_reg <= row_width_next;
            col_reg       <= col_next;
            lmc_reg       <= lmc_next;
            seen_reg      <= seen_next;
        end
    end

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, col_reg} < eff_w)
        else $error("column past row end");

    a_lmc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> (lmc_reg == '0))
        else $error("marker column set with no marker seen");

    a_lmc_behind: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> (lmc_reg < col_reg))
        else $error("marker column not behind column");

endmodule

`default_nettype wire

>>> hdl/rpse_obuf.sv
// Output register with a skid stage for the code channel.
// Depends on rpse_pkg.
`default_nettype none

module rpse_obuf (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  rpse_pkg::rpse_result_t      push_data,
    output logic                        space,
    output logic                        out_valid,
    output rpse_pkg::rpse_result_t      out_data,
    input  wire logic                   out_ready
);
    import rpse_pkg::*;

    logic         out_valid_reg, out_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    rpse_result_t out_data_reg;
    rpse_result_t skid_data_reg;
    logic         out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || push;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = skid_valid_reg || push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        if (push && !out_free)
        begin
            skid_data_reg <= push_data;
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while output empty");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("push into full buffer");

    a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("output changed while stalled");

endmodule

`default_nettype wire

>>> hdl/row_position_symbol_encoder.sv
// Row position symbol encoder, top level.
// Takes one 2-bit marker symbol per request and gives a right aligned codeword.
// Channels: symbols (sink), codes (source), cfg (row width write, sink).
// Each symbol is encoded in the cycle it is accepted; its codeword is then
// registered in the output register, or in the skid stage while codes stalls.
// Throughput is one symbol per cycle while symbols.ready is high; each accepted
// symbol updates the column / last-marker state.
// Zero symbols give no codeword except in the last column of a row.
// When codes stalls, one more codeword lands in the skid stage; symbols.ready
// drops only while the skid stage is full, and resumes once codes takes one.
// Reset: row width 4096, row restarts at column 0, output empty.
// A row width write restarts the current row; cfg.ready is always high and
// writes are expected only while no symbol is in flight.
// Depends on rpse_pkg, rpse_ifs, rpse_core, rpse_obuf.
`default_nettype none

module row_position_symbol_encoder (
    input  wire logic    clk,
    input  wire logic    rst_n,
    rpse_sym_if.sink     symbols,
    rpse_code_if.source  codes,
    rpse_cfg_if.sink     cfg
);
    import rpse_pkg::*;

    logic         accept;
    logic         cfg_we;
    logic         res_valid;
    rpse_result_t res;
    logic         space;
    logic         out_valid;
    rpse_result_t out_data;

    assign symbols.ready = space;
    assign cfg.ready     = 1'b1;
    assign accept        = symbols.valid && space;
    assign cfg_we        = cfg.valid;

    rpse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .symbol    (symbols.symbol),
        .cfg_we    (cfg_we),
        .cfg_width (cfg.row_width),
        .res_valid (res_valid),
        .res       (res)
    );

    rpse_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_ready (codes.ready)
    );

    assign codes.valid       = out_valid;
    assign codes.code_bits   = out_data.code_bits;
    assign codes.code_length = out_data.code_length;
    assign codes.row_done    = out_data.row_done;

    a_marker_gives_code: assert property (@(posedge clk) disable iff (!rst_n)
        (symbols.valid && symbols.ready && (symbols.symbol != SYM_NONE)) |=> codes.valid)
        else $error("marker accepted with no codeword");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        codes.valid |-> (codes.code_length != '0))
        else $error("empty codeword");

    a_single_bit_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (codes.valid && (codes.code_length == LEN_W'(1))) |-> codes.row_done)
        else $error("single bit code outside last column");

endmodule

`default_nettype wire

>>> dv/row_position_symbol_encoder_tb.sv
// Testbench for row_position_symbol_encoder: directed rows and width clamps,
// then random symbol rows under source idling and sink stalls, self-checked.
// Depends on rpse_pkg, rpse_ifs and the RTL top level.
`default_nettype none

module row_position_symbol_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpse_pkg::*;

    logic clk;
    logic rst_n;

    rpse_sym_if  symbols_ch ();
    rpse_code_if codes_ch ();
    rpse_cfg_if  cfg_ch ();

    row_position_symbol_encoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (symbols_ch),
        .codes   (codes_ch),
        .cfg     (cfg_ch)
    );

    rpse_result_t pending_codes[$];
    int           mismatches;
    int           src_idle_pct;
    int           snk_stall_pct;

    // encoder state mirror
    logic [RW_W-1:0]  model_width;
    logic [COL_W-1:0] model_col;
    logic [COL_W-1:0] model_last;
    logic             model_seen;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("FAIL row_position_symbol_encoder");
        $finish;
    end

    function automatic bit encode_symbol(input logic [SYM_W-1:0] sym,
                                         output rpse_result_t res);
        int unsigned      w;
        int unsigned      span;
        int unsigned      nbits;
        int unsigned      gap;
        int unsigned      code;
        logic [2:0]       pre;
        logic [LEN_W-1:0] plen;
        bit               last;
        bit               has_code;
        w = int'(model_width);
        if (w < 1)
            w = 1;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        last = (int'(model_col) + 1 >= w);
        has_code = 1'b0;
        res = '0;
        if (sym == SYM_NONE)
        begin
            if (last)
            begin
                res.code_length = LEN_W'(1);
                res.row_done = 1'b1;
                has_code = 1'b1;
            end
        end
        else
        begin
            case (sym)
                SYM_START:
                begin
                    pre = PRE_START;
                    plen = PLEN_START;
                end
                SYM_END:
                begin
                    pre = PRE_END;
                    plen = PLEN_OTHER;
                end
                default:
                begin
                    pre = PRE_SINGLE;
                    plen = PLEN_OTHER;
                end
            endcase
            span = w - int'(model_last) - int'(model_seen);
            if (span < 1)
                span = 1;
            nbits = 0;
            while ((1 << nbits) < span)
                nbits++;
            if (nbits == 0)
                nbits = 1;
            gap = model_seen ? int'(model_col) - int'(model_last) - 1 : int'(model_col);
            gap &= (1 << nbits) - 1;
            code = (int'(pre) << nbits) | gap;
            res.code_bits = CODE_W'(code);
            res.code_length = LEN_W'(int'(plen) + nbits);
            res.row_done = last;
            has_code = 1'b1;
            model_last = model_col;
            model_seen = 1'b1;
        end
        if (last)
        begin
            model_col = '0;
            model_last = '0;
            model_seen = 1'b0;
        end
        else
        begin
            model_col = model_col + COL_W'(1);
        end
        return has_code;
    endfunction

    // sink side: random ready, compare every accepted codeword
    initial
    begin
        rpse_result_t got;
        rpse_result_t want;
        codes_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && codes_ch.valid && codes_ch.ready)
            begin
                got.code_bits = codes_ch.code_bits;
                got.code_length = codes_ch.code_length;
                got.row_done = codes_ch.row_done;
                if (pending_codes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected code: bits %h len %0d done %0b", $time,
                             got.code_bits, got.code_length, got.row_done);
                end
                else
                begin
                    want = pending_codes.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: code mismatch: expected bits %h len %0d done %0b,",
                                 $time, want.code_bits, want.code_length, want.row_done);
                        $display("%0t:                actual   bits %h len %0d done %0b",
                                 $time, got.code_bits, got.code_length, got.row_done);
                    end
                end
            end
            codes_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic send_symbol(input logic [SYM_W-1:0] sym);
        rpse_result_t res;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct)
        begin
            symbols_ch.valid <= 1'b0;
            symbols_ch.symbol <= SYM_W'($urandom);
            @(posedge clk);
        end
        symbols_ch.valid <= 1'b1;
        symbols_ch.symbol <= sym;
        do
            @(posedge clk);
        while (!symbols_ch.ready);
        if (encode_symbol(sym, res))
            pending_codes.insert(pending_codes.size(), res);
    endtask

    // idle the input and let every codeword drain out
    task automatic wait_idle();
        symbols_ch.valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_row_width(input logic [RW_W-1:0] width);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.row_width <= width;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        model_width = width;
        model_col = '0;
        model_last = '0;
        model_seen = 1'b0;
    endtask

    // reset width 4096: widest gap field, first markers of a row
    task automatic test_reset_width();
        send_symbol(SYM_START);
        send_symbol(SYM_END);
        send_symbol(SYM_SINGLE);
        send_symbol(SYM_NONE);
    endtask

    // zero width acts as one: every symbol is the last column
    task automatic test_width_floor();
        write_row_width('0);
        send_symbol(SYM_NONE);
        send_symbol(SYM_START);
        send_symbol(SYM_END);
        send_symbol(SYM_SINGLE);
        send_symbol(SYM_NONE);
    endtask

    // all-ones width clamps to MAX_WIDTH, longest codewords
    task automatic test_width_ceiling();
        write_row_width('1);
        send_symbol(SYM_START);
        send_symbol(SYM_SINGLE);
        send_symbol(SYM_END);
        send_symbol(SYM_NONE);
    endtask

    // short rows: markers and zeros in the last column, row wrap
    task automatic test_short_rows();
        write_row_width(RW_W'(1));
        send_symbol(SYM_SINGLE);
        send_symbol(SYM_NONE);
        write_row_width(RW_W'(2));
        send_symbol(SYM_NONE);
        send_symbol(SYM_START);
        send_symbol(SYM_END);
        send_symbol(SYM_END);
        write_row_width(RW_W'(3));
        send_symbol(SYM_START);
        send_symbol(SYM_NONE);
        send_symbol(SYM_SINGLE);
        send_symbol(SYM_NONE);
        send_symbol(SYM_NONE);
        send_symbol(SYM_NONE);
    endtask

    // random widths and rows; mostly start/end pairs with singles and gaps
    task automatic test_random_rows(input int src_pct, input int snk_pct, input int n_items);
        int               sent;
        int               seg_len;
        int               w;
        bit               framed;
        bit               open_block;
        logic [RW_W-1:0]  width;
        logic [SYM_W-1:0] sym;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(15))
                0:       width = RW_W'($urandom);
                1, 2:    width = RW_W'($urandom_range(300, 25));
                default: width = RW_W'($urandom_range(24, 1));
            endcase
            write_row_width(width);
            w = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : int'(width));
            if (w <= 24)
                seg_len = w * $urandom_range(5, 1) + $urandom_range(w - 1, 0);
            else
                seg_len = $urandom_range(80, 20);
            if ($urandom_range(3) == 0)
            begin
                src_idle_pct = 0;
                snk_stall_pct = 0;
            end
            else
            begin
                src_idle_pct = src_pct;
                snk_stall_pct = snk_pct;
            end
            framed = ($urandom_range(9) < 7);
            open_block = 1'b0;
            repeat (seg_len)
            begin
                if (!framed)
                    sym = SYM_W'($urandom);
                else if ($urandom_range(1) == 0)
                    sym = SYM_NONE;
                else if (open_block)
                    sym = SYM_END;
                else
                    sym = ($urandom_range(2) == 0) ? SYM_SINGLE : SYM_START;
                if (sym == SYM_START)
                    open_block = 1'b1;
                else if (sym == SYM_END)
                    open_block = 1'b0;
                send_symbol(sym);
            end
            sent += seg_len;
        end
    endtask

    initial
    begin
        mismatches = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        model_width = ROW_WIDTH_RESET;
        model_col = '0;
        model_last = '0;
        model_seen = 1'b0;
        symbols_ch.valid <= 1'b0;
        symbols_ch.symbol <= SYM_NONE;
        cfg_ch.valid <= 1'b0;
        cfg_ch.row_width <= '0;
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_width();
        test_width_floor();
        test_width_ceiling();
        test_short_rows();
        test_random_rows(0, 0, 285);
        test_random_rows(49, 0, 285);
        test_random_rows(0, 49, 285);
        test_random_rows(27, 27, 285);
        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS row_position_symbol_encoder");
        else
            $display("FAIL row_position_symbol_encoder");
        $finish;
    end

endmodule

`default_nettype wire

>>> row_position_symbol_encoder.f
hdl/rpse_pkg.sv
hdl/rpse_ifs.sv
hdl/rpse_core.sv
hdl/rpse_obuf.sv
hdl/row_position_symbol_encoder.sv
dv/row_position_symbol_encoder_tb.sv
